// File: sv/aob_pkg.sv
// ----------------------------------------------------------------------------
// aob_pkg
// Shared widths, constants and types for the alpha-over blend pipeline.
// ----------------------------------------------------------------------------
package aob_pkg;

    localparam int CHAN_W    = 8;
    localparam int PROD_W    = 2 * CHAN_W;   // 8x8 product
    localparam int NUM_W     = 3 * CHAN_W;   // colour numerator, at most 255^3
    localparam int DEN_W     = 2 * CHAN_W;   // 255 * out_a
    localparam int RECIP_W   = 32;

    localparam logic [CHAN_W-1:0] CH_MAX      = 8'd255;
    localparam logic [PROD_W-1:0] CH_MAX_SQ   = 16'd65025;
    // floor(x / 255) == (x * 32897) >> 23 for every x <= 65025
    localparam logic [PROD_W-1:0] RECIP_MUL   = 16'd32897;
    localparam int                RECIP_SHIFT = 23;

    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = CHAN_W / BITS_PER_STAGE;
    localparam int FRONT_STAGES   = 3;
    localparam int LATENCY        = FRONT_STAGES + DIV_STAGES;

    typedef logic [CHAN_W-1:0]  chan_t;
    typedef logic [PROD_W-1:0]  prod_t;
    typedef logic [NUM_W-1:0]   num_t;
    typedef logic [DEN_W-1:0]   den_t;
    typedef logic [RECIP_W-1:0] recip_t;

endpackage

// File: sv/alpha_over_blend.sv
// ----------------------------------------------------------------------------
// alpha_over_blend
// Straight-alpha RGBA8 "over" compositing, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low. The
//   new (top) and old (bottom) pixel channels are sampled on that edge.
//   busy stays low: the pipeline takes one request every cycle.
//   Each result appears on out_r/g/b/a for exactly one cycle, marked by done,
//   after its request passes three front stages (channel products, colour
//   numerators and the alpha reciprocal multiply, then alpha and divisor)
//   and four divider stages, two quotient bits each.
//   Throughput is one pixel per clock, set by the fully staged divider.
//   Results leave in request order. The receiver cannot stall, so no result
//   is ever held back. An asynchronous reset clears all valid bits; requests
//   in flight are dropped and done stays low until new requests arrive.
//   Colour quotients above 255 saturate; a zero combined alpha gives zero
//   colour.
// ----------------------------------------------------------------------------
module alpha_over_blend
    import aob_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  chan_t new_r,
    input  chan_t new_g,
    input  chan_t new_b,
    input  chan_t new_a,
    input  chan_t old_r,
    input  chan_t old_g,
    input  chan_t old_b,
    input  chan_t old_a,
    output logic  done,
    output chan_t out_r,
    output chan_t out_g,
    output chan_t out_b,
    output chan_t out_a
);

    logic  accept;
    chan_t cn [3];
    chan_t co [3];
    chan_t quot [3];

    // stage 1
    logic  v1_reg;
    prod_t pn_reg [3];
    prod_t po_reg [3];
    chan_t ia_reg;
    prod_t anum_reg;
    // stage 2
    logic   v2_reg;
    num_t   num2_reg [3];
    recip_t recip_reg;
    // stage 3
    logic  v3_reg;
    num_t  num3_reg [3];
    den_t  den_reg;
    chan_t oa3_reg;
    chan_t oa_next;
    // divider delay line
    logic  vd_reg [DIV_STAGES];
    chan_t oad_reg [DIV_STAGES];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign cn[0] = new_r;
    assign cn[1] = new_g;
    assign cn[2] = new_b;
    assign co[0] = old_r;
    assign co[1] = old_g;
    assign co[2] = old_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                vd_reg[i] <= 1'b0;
            end
        end
        else
        begin
            v1_reg    <= accept;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            vd_reg[0] <= v3_reg;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                vd_reg[i] <= vd_reg[i-1];
            end
        end
    end

    assign oa_next = recip_reg[RECIP_SHIFT +: CHAN_W];

    // payload, no reset
    always_ff @(posedge clk)
    begin
        ia_reg   <= CH_MAX - new_a;
        anum_reg <= CH_MAX_SQ - prod_t'(CH_MAX - old_a) * prod_t'(CH_MAX - new_a);
        for (int c = 0; c < 3; c++)
        begin
            pn_reg[c] <= prod_t'(cn[c]) * prod_t'(new_a);
            po_reg[c] <= prod_t'(co[c]) * prod_t'(old_a);
        end

        recip_reg <= recip_t'(anum_reg) * recip_t'(RECIP_MUL);
        for (int c = 0; c < 3; c++)
        begin
            // cn*an*255 + co*ao*(255-an)
            num2_reg[c] <= (num_t'({pn_reg[c], 8'b0}) - num_t'(pn_reg[c]))
                           + num_t'(po_reg[c]) * num_t'(ia_reg);
        end

        oa3_reg <= oa_next;
        den_reg <= {oa_next, 8'b0} - den_t'(oa_next);
        for (int c = 0; c < 3; c++)
        begin
            num3_reg[c] <= num2_reg[c];
        end

        oad_reg[0] <= oa3_reg;
        for (int i = 1; i < DIV_STAGES; i++)
        begin
            oad_reg[i] <= oad_reg[i-1];
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        aob_div u_div (
            .clk  (clk),
            .num  (num3_reg[c]),
            .den  (den_reg),
            .quot (quot[c])
        );
    end

    assign done  = vd_reg[DIV_STAGES-1];
    assign out_a = oad_reg[DIV_STAGES-1];
    assign out_r = (out_a == '0) ? '0 : quot[0];
    assign out_g = (out_a == '0) ? '0 : quot[1];
    assign out_b = (out_a == '0) ? '0 : quot[2];

endmodule

// File: sv/aob_div.sv
// ----------------------------------------------------------------------------
// aob_div
// Pipelined restoring divider, two quotient bits per stage, saturating at 255.
// ----------------------------------------------------------------------------
module aob_div
    import aob_pkg::*;
(
    input  logic  clk,
    input  num_t  num,
    input  den_t  den,
    output chan_t quot
);

    num_t  rem_reg [DIV_STAGES-1];
    den_t  den_reg [DIV_STAGES-1];
    chan_t q_reg   [DIV_STAGES];
    logic  sat_reg [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        num_t  rem_in;
        den_t  den_in;
        chan_t q_in;
        logic  sat_in;
        num_t  rem_next;
        chan_t q_next;

        if (s == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign q_in   = '0;
            // quotient of 256 or more saturates
            assign sat_in = (num >= {den, 8'b0});
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign q_in   = q_reg[s-1];
            assign sat_in = sat_reg[s-1];
        end

        always_comb
        begin
            num_t       trial;
            logic [2:0] bit_pos;
            rem_next = rem_in;
            q_next   = q_in;
            for (int j = 0; j < BITS_PER_STAGE; j++)
            begin
                bit_pos = 3'(CHAN_W - 1 - s * BITS_PER_STAGE - j);
                trial   = {8'b0, den_in} << bit_pos;
                if (rem_next >= trial)
                begin
                    rem_next        = rem_next - trial;
                    q_next[bit_pos] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            q_reg[s]   <= q_next;
            sat_reg[s] <= sat_in;
        end

        if (s < DIV_STAGES - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[s] <= rem_next;
                den_reg[s] <= den_in;
            end
        end
    end

    assign quot = sat_reg[DIV_STAGES-1] ? CH_MAX : q_reg[DIV_STAGES-1];

endmodule

// File: sv/aob_checker.sv
// ----------------------------------------------------------------------------
// aob_checker
// Port-level checks for alpha_over_blend, bound to the top level.
// ----------------------------------------------------------------------------
module aob_checker
    import aob_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  start,
    input logic  busy,
    input chan_t new_r,
    input chan_t new_g,
    input chan_t new_b,
    input chan_t new_a,
    input chan_t old_r,
    input chan_t old_g,
    input chan_t old_b,
    input chan_t old_a,
    input logic  done,
    input chan_t out_r,
    input chan_t out_g,
    input chan_t out_b,
    input chan_t out_a
);

    // every request gives exactly one result, a fixed latency later
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("request produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##LATENCY !done)
        else $error("result without request");

    a_zero_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_a == '0) |-> (out_r == '0 && out_g == '0 && out_b == '0))
        else $error("nonzero colour with zero alpha");

    // combined alpha never drops below either source alpha
    a_alpha_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY
        (out_a >= $past(new_a, LATENCY) && out_a >= $past(old_a, LATENCY)))
        else $error("combined alpha below a source alpha");

    // opaque top pixel passes through unchanged
    a_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && new_a == CH_MAX) |-> ##LATENCY
        (out_a == CH_MAX && out_r == $past(new_r, LATENCY)
         && out_g == $past(new_g, LATENCY) && out_b == $past(new_b, LATENCY)))
        else $error("opaque pixel not passed through");

endmodule

bind alpha_over_blend aob_checker u_aob_checker (.*);

// File: tb/sv/blend_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blend_checker
// Watches the request and result ports of alpha_over_blend, predicts the
// composite pixel of every accepted request and compares each result, field
// by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module blend_checker
    import aob_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  busy,
    input  chan_t new_r,
    input  chan_t new_g,
    input  chan_t new_b,
    input  chan_t new_a,
    input  chan_t old_r,
    input  chan_t old_g,
    input  chan_t old_b,
    input  chan_t old_a,
    input  logic  done,
    input  chan_t out_r,
    input  chan_t out_g,
    input  chan_t out_b,
    input  chan_t out_a,
    output int    errors,
    output int    pending
);

    localparam int unsigned FULL_SCALE = 255;

    typedef struct packed {
        chan_t r;
        chan_t g;
        chan_t b;
        chan_t a;
    } rgba_t;

    rgba_t composite_q[$];

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    function automatic chan_t blend_color(int unsigned cn, int unsigned co,
                                          int unsigned an, int unsigned ao,
                                          int unsigned alpha);
        int unsigned num;
        int unsigned quo;
        if (alpha == 0)
            return '0;
        num = cn * an * FULL_SCALE + co * ao * (FULL_SCALE - an);
        quo = num / (FULL_SCALE * alpha);
        return (quo > FULL_SCALE) ? chan_t'(FULL_SCALE) : chan_t'(quo);
    endfunction

    function automatic rgba_t composite_over(chan_t nr, chan_t ng, chan_t nb, chan_t na,
                                             chan_t orr, chan_t og, chan_t ob, chan_t oa);
        int unsigned alpha;
        rgba_t px;
        alpha = (FULL_SCALE * FULL_SCALE - (FULL_SCALE - oa) * (FULL_SCALE - na))
                / FULL_SCALE;
        px.r = blend_color(nr, orr, na, oa, alpha);
        px.g = blend_color(ng, og, na, oa, alpha);
        px.b = blend_color(nb, ob, na, oa, alpha);
        px.a = chan_t'(alpha);
        return px;
    endfunction

    task automatic compare_field(string name, chan_t exp_v, chan_t act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d",
                     $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rgba_t exp_px;
        if (!rst_n)
        begin
            composite_q.delete();
            pending = 0;
        end
        else
        begin
            // push first so a zero-latency result would still find its request
            if (start && !busy)
                composite_q.push_back(composite_over(new_r, new_g, new_b, new_a,
                                                     old_r, old_g, old_b, old_a));
            if (done)
            begin
                if (composite_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual r=%0d g=%0d b=%0d a=%0d",
                             $time, out_r, out_g, out_b, out_a);
                    errors++;
                end
                else
                begin
                    exp_px = composite_q.pop_front();
                    compare_field("out_r", exp_px.r, out_r);
                    compare_field("out_g", exp_px.g, out_g);
                    compare_field("out_b", exp_px.b, out_b);
                    compare_field("out_a", exp_px.a, out_a);
                end
            end
            pending = composite_q.size();
        end
    end

endmodule

// File: tb/sv/alpha_over_blend_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_over_blend_tb
// Drives pixel pairs into alpha_over_blend: a directed set of alpha and color
// corners, then random pairs under several sender idle patterns. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module alpha_over_blend_tb
    import aob_pkg::*;
();

    localparam int NUM_RANDOM  = 1500;
    localparam int STALL_LIMIT = 2000;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    chan_t new_r, new_g, new_b, new_a;
    chan_t old_r, old_g, old_b, old_a;
    logic  done;
    chan_t out_r, out_g, out_b, out_a;
    int    errors;
    int    pending;
    int    idle_pct;
    int    stall_cnt;

    alpha_over_blend dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .new_r (new_r),
        .new_g (new_g),
        .new_b (new_b),
        .new_a (new_a),
        .old_r (old_r),
        .old_g (old_g),
        .old_b (old_b),
        .old_a (old_a),
        .done  (done),
        .out_r (out_r),
        .out_g (out_g),
        .out_b (out_b),
        .out_a (out_a)
    );

    blend_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .new_r   (new_r),
        .new_g   (new_g),
        .new_b   (new_b),
        .new_a   (new_a),
        .old_r   (old_r),
        .old_g   (old_g),
        .old_b   (old_b),
        .old_a   (old_a),
        .done    (done),
        .out_r   (out_r),
        .out_g   (out_g),
        .out_b   (out_b),
        .out_a   (out_a),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // no progress for too long: hung pipeline or lost result
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cnt <= 0;
        else if (stall_cnt >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            stall_cnt <= stall_cnt + 1;
    end

    // mostly uniform, with a bias toward the alpha and color edges
    function automatic chan_t rand_chan();
        if ($urandom_range(99) >= 30)
            return chan_t'($urandom_range(255));
        case ($urandom_range(5))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd127;
            3:       return 8'd128;
            4:       return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    // called right after a rising edge; returns right after the accepting edge
    task automatic send_pixel(chan_t nr, chan_t ng, chan_t nb, chan_t na,
                              chan_t orr, chan_t og, chan_t ob, chan_t oa);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        new_r <= nr;
        new_g <= ng;
        new_b <= nb;
        new_a <= na;
        old_r <= orr;
        old_g <= og;
        old_b <= ob;
        old_a <= oa;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    initial
    begin
        start    <= 1'b0;
        new_r    <= '0;
        new_g    <= '0;
        new_b    <= '0;
        new_a    <= '0;
        old_r    <= '0;
        old_g    <= '0;
        old_b    <= '0;
        old_a    <= '0;
        rst_n    <= 1'b0;
        idle_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero combined alpha, with and without color
        send_pixel(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd0);
        send_pixel(8'hAA,  8'h55,  8'hFF,  8'd0,   8'h55,  8'hAA,  8'h01,  8'd0);
        // opaque top, opaque bottom, both, then half alpha
        send_pixel(8'd10,  8'd200, 8'd77,  8'd255, 8'd99,  8'd3,   8'd250, 8'd0);
        send_pixel(8'd10,  8'd200, 8'd77,  8'd0,   8'd99,  8'd3,   8'd250, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd128, 8'd128, 8'd0,   8'd255, 8'd127, 8'd127);
        // tiny alphas: floored alpha can drive the color quotient past full scale
        send_pixel(8'd255, 8'd255, 8'd255, 8'd1,   8'd255, 8'd255, 8'd255, 8'd1);
        send_pixel(8'd200, 8'd255, 8'd17,  8'd1,   8'd255, 8'd180, 8'd254, 8'd2);
        send_pixel(8'd255, 8'd254, 8'd1,   8'd2,   8'd254, 8'd255, 8'd0,   8'd1);
        send_pixel(8'd128, 8'd64,  8'd32,  8'd1,   8'd16,  8'd8,   8'd4,   8'd0);
        send_pixel(8'd1,   8'd2,   8'd4,   8'd0,   8'd8,   8'd16,  8'd32,  8'd1);
        // near opaque, then mixed alphas
        send_pixel(8'd254, 8'd1,   8'd127, 8'd254, 8'd1,   8'd254, 8'd128, 8'd254);
        send_pixel(8'h55,  8'hAA,  8'h0F,  8'hF0,  8'hAA,  8'h55,  8'hF0,  8'h0F);
        send_pixel(8'h0F,  8'hF0,  8'hAA,  8'h55,  8'hF0,  8'h0F,  8'h55,  8'hAA);
        drain();

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i % (NUM_RANDOM / 4) == 0)
            begin
                drain();
                case (i / (NUM_RANDOM / 4))
                    0:       idle_pct = 0;
                    1:       idle_pct = 79;
                    2:       idle_pct = 8;
                    default: idle_pct = 0;
                endcase
            end
            send_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan(),
                       rand_chan(), rand_chan(), rand_chan(), rand_chan());
        end

        drain();
        repeat (LATENCY + 4) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
sv/aob_pkg.sv
sv/aob_div.sv
sv/alpha_over_blend.sv
sv/aob_checker.sv
tb/sv/blend_checker.sv
tb/sv/alpha_over_blend_tb.sv
